/* hw/rtl/gfbs_pkg.sv */
package gfbs_pkg;

  localparam int ROW_COUNT     = 7;
  localparam int BYTES_PER_ROW = 35;
  localparam int STORE_SIZE    = ROW_COUNT * BYTES_PER_ROW;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  localparam int ROW_W         = 3;
  localparam int IDX_W         = $clog2(BYTES_PER_ROW);
  localparam int COL_W         = 7;
  localparam int CURSOR_W      = 9;
  localparam int GLYPH_W       = 56;

  localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_START  = 3'd1,
    OP_GLYPH  = 3'd2,
    OP_FINISH = 3'd3,
    OP_SCAN   = 3'd4,
    OP_BLANK  = 3'd5
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RMW_RD   = 6'b000010,
    ST_RMW_WR   = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_OUT = 6'b010000,
    ST_SEL_OUT  = 6'b100000
  } state_t;

  function automatic logic [7:0] row_select(input logic [ROW_W-1:0] row);
    logic [7:0] code;
    unique case (row)
      3'd0:    code = 8'h80;
      3'd1:    code = 8'h40;
      3'd2:    code = 8'hC0;
      3'd3:    code = 8'h20;
      3'd4:    code = 8'hA0;
      3'd5:    code = 8'h60;
      3'd6:    code = 8'hE0;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/glyph_framebuffer_blit_scan_unit.sv */
// channel | handshake           | payload
// input   | in_valid / in_stall | opcode start_bit end_bit glyph_rows glyph_width invert row_index
// output  | out_valid/out_stall | out_byte byte_kind last_of_run
//
// Clear, start: done on acceptance. Glyph, finish: two read-modify-writes per row
// through the single-port store, each a read state then a write state. Scan: a read and
// an output state per byte, then the select byte; row 7 skips reads. Blank: select byte.
// Reset (and clear) zero the store at once through per-entry valid bits.
// in_stall is high while a command is in progress; out_stall holds the output register
// and pauses a scan.
module glyph_framebuffer_blit_scan_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   opcode,
  input  logic [gfbs_pkg::CURSOR_W-1:0] start_bit,
  input  logic [gfbs_pkg::CURSOR_W-1:0] end_bit,
  input  logic [gfbs_pkg::GLYPH_W-1:0]  glyph_rows,
  input  logic [3:0]                   glyph_width,
  input  logic                         invert,
  input  logic [gfbs_pkg::ROW_W-1:0]    row_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         byte_kind,
  output logic                         last_of_run
);
  import gfbs_pkg::*;

  state_t state, state_next;

  logic [CURSOR_W-1:0] bit_cursor;
  logic [CURSOR_W-1:0] string_end;
  logic                string_open;

  logic [7:0]        mem [STORE_SIZE];
  logic [STORE_SIZE-1:0] valid;
  logic [7:0]        rd_q;
  logic              rd_vld;
  logic [7:0]        rd_val;

  logic [GLYPH_W-1:0] glyph_q;
  logic [2:0]         shift_q;
  logic [7:0]         keep_q;
  logic               is_and;
  logic               is_glyph;
  logic               phase;
  logic [COL_W-1:0]   col_base;
  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  row_base;
  logic [IDX_W-1:0]   idx;
  logic               row_ok;
  logic               inv_q;
  logic [7:0]         sel_q;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [7:0]         out_byte_next;
  logic               byte_kind_next;
  logic               last_next;

  logic [ADDR_W:0]    addr_sum;
  logic [ADDR_W-1:0]  addr;
  logic               rmw_in_range;
  logic               rd_en;
  logic               wr_en;
  logic [7:0]         wdata;
  logic [7:0]         row_byte;
  logic [15:0]        shifted;
  logic [7:0]         operand;
  logic [CURSOR_W:0]  cursor_sum;
  logic               glyph_go;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign rd_val   = rd_vld ? rd_q : 8'h00;

  assign cursor_sum = {1'b0, bit_cursor} + {{(CURSOR_W-3){1'b0}}, glyph_width};
  assign glyph_go   = string_open && (bit_cursor <= string_end);

  // shared read-modify-write datapath
  assign row_byte = glyph_q[{row, 3'b000} +: 8];
  assign shifted  = {8'h00, row_byte} << shift_q;
  always_comb begin
    if (is_glyph) begin
      operand = phase ? shifted[15:8] : shifted[7:0];
    end else begin
      operand = phase ? 8'h00 : keep_q;
    end
  end
  assign wdata = is_and ? (rd_val & operand) : (rd_val | operand);

  always_comb begin
    if (state == ST_SCAN_RD) begin
      addr_sum = {1'b0, row_base} + {{(ADDR_W+1-IDX_W){1'b0}}, idx};
    end else begin
      addr_sum = {1'b0, row_base} + {{(ADDR_W+1-COL_W){1'b0}}, col_cur};
    end
  end
  assign addr         = addr_sum[ADDR_W-1:0];
  assign rmw_in_range = (col_cur < COL_W'(BYTES_PER_ROW));
  assign rd_en = ((state == ST_RMW_RD) && rmw_in_range) || ((state == ST_SCAN_RD) && row_ok);
  assign wr_en = (state == ST_RMW_WR) && rmw_in_range;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_q   <= mem[addr];
      rd_vld <= valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && (opcode == OP_CLEAR))) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[addr] <= 1'b1;
    end
  end

  always_comb begin
    state_next     = state;
    out_load       = 1'b0;
    out_byte_next  = 8'h00;
    byte_kind_next = 1'b0;
    last_next      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (opcode)
            OP_GLYPH:  state_next = glyph_go ? ST_RMW_RD : ST_IDLE;
            OP_FINISH: state_next = ST_RMW_RD;
            OP_SCAN:   state_next = (row_index < ROW_W'(ROW_COUNT)) ? ST_SCAN_RD : ST_SCAN_OUT;
            OP_BLANK:  state_next = ST_SEL_OUT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_RMW_RD: state_next = ST_RMW_WR;
      ST_RMW_WR: begin
        if (phase && (row == ROW_W'(ROW_COUNT - 1))) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RMW_RD;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_OUT;
      ST_SCAN_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_byte_next = (row_ok ? rd_val : 8'h00) ^ {8{inv_q}};
          if (idx == '0) begin
            state_next = ST_SEL_OUT;
          end else begin
            state_next = row_ok ? ST_SCAN_RD : ST_SCAN_OUT;
          end
        end
      end
      ST_SEL_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_next  = sel_q;
          byte_kind_next = 1'b1;
          last_next      = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bit_cursor  <= '0;
      string_end  <= '0;
      string_open <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (opcode == OP_START)) begin
        bit_cursor  <= start_bit;
        string_end  <= end_bit;
        string_open <= 1'b1;
      end else if (accept && (opcode == OP_GLYPH) && glyph_go) begin
        bit_cursor <= cursor_sum[CURSOR_W] ? CURSOR_MAX : cursor_sum[CURSOR_W-1:0];
      end else if (accept && (opcode == OP_FINISH)) begin
        string_open <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte    <= out_byte_next;
      byte_kind   <= byte_kind_next;
      last_of_run <= last_next;
    end
    if (accept) begin
      glyph_q  <= glyph_rows;
      inv_q    <= invert;
      row      <= '0;
      phase    <= 1'b0;
      idx      <= IDX_W'(BYTES_PER_ROW - 1);
      row_ok   <= (row_index < ROW_W'(ROW_COUNT));
      sel_q    <= (opcode == OP_SCAN) ? row_select(row_index) : 8'h00;
      is_glyph <= (opcode == OP_GLYPH);
      is_and   <= (opcode == OP_FINISH);
      if (opcode == OP_SCAN) begin
        row_base <= ADDR_W'(row_index * BYTES_PER_ROW);
      end else begin
        row_base <= '0;
      end
      if (opcode == OP_GLYPH) begin
        shift_q  <= bit_cursor[2:0];
        col_base <= {1'b0, bit_cursor[CURSOR_W-1:3]};
        col_cur  <= {1'b0, bit_cursor[CURSOR_W-1:3]};
      end else begin
        shift_q  <= string_end[2:0];
        col_base <= {1'b0, string_end[CURSOR_W-1:3]};
        col_cur  <= {1'b0, string_end[CURSOR_W-1:3]};
      end
      keep_q <= (8'h01 << string_end[2:0]) - 8'h01;
    end else if (state == ST_RMW_WR) begin
      if (!phase) begin
        phase   <= 1'b1;
        col_cur <= col_base + COL_W'(1);
      end else begin
        phase    <= 1'b0;
        col_cur  <= col_base;
        row      <= row + ROW_W'(1);
        row_base <= row_base + ADDR_W'(BYTES_PER_ROW);
      end
    end else if ((state == ST_SCAN_OUT) && out_free && (idx != '0)) begin
      idx <= idx - IDX_W'(1);
    end
  end

endmodule

/* tb/sv/glyph_framebuffer_blit_scan_unit_tb.sv */
`timescale 1ns / 1ps

module glyph_framebuffer_blit_scan_unit_tb;
  import gfbs_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int LAST_COL        = 271;
  localparam int RANDOM_CMDS     = 375;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_AT         = 400;
  localparam int HOLD_LEN        = 300;
  localparam int DRAIN_CYCLES    = 80;
  localparam logic [7:0] SEL_CODE [8] = '{8'h80, 8'h40, 8'hC0, 8'h20,
                                          8'hA0, 8'h60, 8'hE0, 8'h00};

  typedef struct packed {
    logic [2:0]          opcode;
    logic [CURSOR_W-1:0] start_bit;
    logic [CURSOR_W-1:0] end_bit;
    logic [GLYPH_W-1:0]  glyph_rows;
    logic [3:0]          glyph_width;
    logic                invert;
    logic [ROW_W-1:0]    row_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_kind;
    logic       last_of_run;
  } disp_byte_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          opcode;
  logic [CURSOR_W-1:0] start_bit;
  logic [CURSOR_W-1:0] end_bit;
  logic [GLYPH_W-1:0]  glyph_rows;
  logic [3:0]          glyph_width;
  logic                invert;
  logic [ROW_W-1:0]    row_index;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                byte_kind;
  logic                last_of_run;

  cmd_t drv_cmd = '0;

  assign opcode      = drv_cmd.opcode;
  assign start_bit   = drv_cmd.start_bit;
  assign end_bit     = drv_cmd.end_bit;
  assign glyph_rows  = drv_cmd.glyph_rows;
  assign glyph_width = drv_cmd.glyph_width;
  assign invert      = drv_cmd.invert;
  assign row_index   = drv_cmd.row_index;

  glyph_framebuffer_blit_scan_unit i_dut (.*);

  // shadow of the display store
  logic [7:0]          frame_mem [STORE_SIZE];
  logic [CURSOR_W-1:0] cur_col = '0;
  logic [CURSOR_W-1:0] str_end = '0;
  logic                str_open = 1'b0;

  cmd_t       cmd_queue [$];
  disp_byte_t expected_bytes [$];

  int total_cmds = 0;
  int useful_cmds = 0;
  int scan_cmds = 0;
  int glyph_cmds = 0;
  int words_in = 0;
  int words_out = 0;
  int mismatches = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  initial begin
    foreach (frame_mem[k]) frame_mem[k] = 8'h00;
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic disp_byte_t mk_byte(input logic [7:0] b, input logic kind,
                                         input logic last);
    disp_byte_t d;
    d.out_byte    = b;
    d.byte_kind   = kind;
    d.last_of_run = last;
    return d;
  endfunction

  function automatic void update_frame_model(input cmd_t c);
    int unsigned col, sh, base;
    logic [7:0]  b, v, keep;
    logic [9:0]  next_col;
    case (c.opcode)
      OP_CLEAR: begin
        foreach (frame_mem[k]) frame_mem[k] = 8'h00;
      end
      OP_START: begin
        cur_col  = c.start_bit;
        str_end  = c.end_bit;
        str_open = 1'b1;
      end
      OP_GLYPH: begin
        if (str_open && cur_col <= str_end) begin
          col = cur_col / 8;
          sh  = cur_col % 8;
          for (int r = 0; r < ROW_COUNT; r++) begin
            b = c.glyph_rows[8*r +: 8];
            base = r * BYTES_PER_ROW;
            if (col < BYTES_PER_ROW) frame_mem[base + col] |= 8'(b << sh);
            if (sh != 0 && col + 1 < BYTES_PER_ROW) frame_mem[base + col + 1] |= b >> (8 - sh);
          end
          next_col = cur_col + c.glyph_width;
          cur_col  = (next_col > CURSOR_MAX) ? CURSOR_MAX : next_col[CURSOR_W-1:0];
        end
      end
      OP_FINISH: begin
        col  = str_end / 8;
        keep = (str_end % 8 == 0) ? 8'h00 : (8'hFF >> (8 - str_end % 8));
        for (int r = 0; r < ROW_COUNT; r++) begin
          base = r * BYTES_PER_ROW;
          if (col + 1 < BYTES_PER_ROW) frame_mem[base + col + 1] = 8'h00;
          if (col < BYTES_PER_ROW) frame_mem[base + col] &= keep;
        end
        str_open = 1'b0;
      end
      OP_SCAN: begin
        for (int i = BYTES_PER_ROW - 1; i >= 0; i--) begin
          v = (c.row_index < ROW_COUNT) ? frame_mem[c.row_index * BYTES_PER_ROW + i] : 8'h00;
          if (c.invert) v = ~v;
          expected_bytes.push_back(mk_byte(v, 1'b0, 1'b0));
        end
        v = (c.row_index < ROW_COUNT) ? SEL_CODE[c.row_index] : 8'h00;
        expected_bytes.push_back(mk_byte(v, 1'b1, 1'b1));
      end
      OP_BLANK: expected_bytes.push_back(mk_byte(8'h00, 1'b1, 1'b1));
      default: ;
    endcase
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] op, input int sb, input int eb,
                                  input logic [GLYPH_W-1:0] rows, input int w,
                                  input logic inv, input int row);
    cmd_t c;
    c.opcode      = op;
    c.start_bit   = CURSOR_W'(sb);
    c.end_bit     = CURSOR_W'(eb);
    c.glyph_rows  = rows;
    c.glyph_width = 4'(w);
    c.invert      = inv;
    c.row_index   = ROW_W'(row);
    return c;
  endfunction

  function automatic cmd_t rnd_cmd(input logic [2:0] op);
    cmd_t c;
    c.opcode      = op;
    c.start_bit   = CURSOR_W'($urandom_range(511, 0));
    c.end_bit     = CURSOR_W'($urandom_range(511, 0));
    c.glyph_rows  = GLYPH_W'({$urandom, $urandom});
    if ($urandom_range(1, 0) == 1) c.glyph_rows &= GLYPH_W'({$urandom, $urandom});
    c.glyph_width = 4'($urandom_range(15, 0));
    c.invert      = 1'($urandom_range(1, 0));
    c.row_index   = ROW_W'($urandom_range(7, 0));
    return c;
  endfunction

  function automatic void queue_cmd(input cmd_t c);
    cmd_queue.push_back(c);
    total_cmds++;
    if (c.opcode <= OP_BLANK) useful_cmds++;
    if (c.opcode == OP_SCAN) scan_cmds++;
    if (c.opcode == OP_GLYPH) glyph_cmds++;
  endfunction

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        update_frame_model(drv_cmd);
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() > 0 &&
            ((words_in >= 150 && words_in < 230) || $urandom_range(99, 0) >= 23)) begin
          drv_cmd  <= cmd_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    disp_byte_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word out_byte %02h kind %0b last %0b",
                   $time, out_byte, byte_kind, last_of_run);
          mismatches++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.out_byte || byte_kind !== e.byte_kind ||
              last_of_run !== e.last_of_run) begin
            $display("%0t: expected byte %02h kind %0b last %0b, actual byte %02h kind %0b last %0b",
                     $time, e.out_byte, e.byte_kind, e.last_of_run,
                     out_byte, byte_kind, last_of_run);
            mismatches++;
          end
        end
        words_out++;
        if (words_out == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (words_out >= 1000 && words_out < 1800) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99, 0) < 23);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("glyph_framebuffer_blit_scan_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t c;
    int   n;

    // empty store, reserved opcodes, glyph with no open string
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b1, 6));
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b1, 7));
    queue_cmd(mk_cmd(OP_BLANK, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_RSVD6, 511, 511, '1, 15, 1'b1, 7));
    queue_cmd(mk_cmd(OP_RSVD7, 511, 511, '1, 15, 1'b1, 7));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 15, 1'b0, 0));
    // full-width string, unaligned cursor, trim at the last column
    queue_cmd(mk_cmd(OP_START, 0, LAST_COL, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 15, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, 56'hA5_5A_C3_3C_81_18_E7, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, 56'h01_02_04_08_10_20_40, 9, 1'b0, 0));
    queue_cmd(mk_cmd(OP_FINISH, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_START, LAST_COL, LAST_COL, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 15, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 15, 1'b0, 0));
    // cursor saturation, writes past the row dropped
    queue_cmd(mk_cmd(OP_START, 505, 511, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 15, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 15, 1'b0, 0));
    queue_cmd(mk_cmd(OP_FINISH, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b1, 3));
    // byte-aligned end clears the whole end byte
    queue_cmd(mk_cmd(OP_START, 16, 16, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_GLYPH, 0, 0, '1, 8, 1'b0, 0));
    queue_cmd(mk_cmd(OP_FINISH, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b0, 1));
    queue_cmd(mk_cmd(OP_CLEAR, 0, 0, '0, 0, 1'b0, 0));
    queue_cmd(mk_cmd(OP_SCAN, 0, 0, '0, 0, 1'b1, 2));

    n = useful_cmds;
    while (useful_cmds - n < RANDOM_CMDS) begin
      if ($urandom_range(99, 0) < 70) begin
        if ($urandom_range(3, 0) == 0) queue_cmd(rnd_cmd(OP_CLEAR));
        c = rnd_cmd(OP_START);
        if ($urandom_range(9, 0) != 0) begin
          c.start_bit = CURSOR_W'($urandom_range(LAST_COL, 0));
          c.end_bit   = CURSOR_W'($urandom_range(LAST_COL, c.start_bit));
        end
        queue_cmd(c);
        repeat ($urandom_range(8, 1)) begin
          c = rnd_cmd(OP_GLYPH);
          if ($urandom_range(4, 0) != 0) c.glyph_width = 4'($urandom_range(8, 3));
          queue_cmd(c);
        end
        if ($urandom_range(9, 0) != 0) queue_cmd(rnd_cmd(OP_FINISH));
        repeat ($urandom_range(2, 1)) queue_cmd(rnd_cmd(OP_SCAN));
        if ($urandom_range(4, 0) == 0) queue_cmd(rnd_cmd(OP_BLANK));
      end else begin
        queue_cmd(rnd_cmd(3'($urandom_range(7, 0))));
      end
    end
    queue_cmd(rnd_cmd(OP_SCAN));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (words_in < total_cmds || expected_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands (%0d glyphs, %0d scans) and checked %0d output words",
             total_cmds, glyph_cmds, scan_cmds, words_out);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("glyph_framebuffer_blit_scan_unit verification clean");
    end else begin
      $display("glyph_framebuffer_blit_scan_unit verification failed");
    end
    $finish;
  end

endmodule
